// File: rtl/core/uor_pkg.sv
package uor_pkg;

  localparam int OVERSAMPLE_DEF = 4;
  localparam int DATA_BITS_DEF  = 8;

  localparam int BYTE_W     = 8;
  localparam int HIST_W     = 4;
  localparam int BIT_IDX_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [HIST_W-1:0]    START_PATTERN   = 4'b1100;
  localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE = 1'd1;

  typedef enum logic [1:0] {
    PM_NONE = 2'd0,
    PM_EVEN = 2'd1,
    PM_ODD  = 2'd2,
    PM_SLOT = 2'd3
  } parity_mode_t;

  typedef enum logic [1:0] {
    PS_NONE     = 2'd0,
    PS_EVEN_OK  = 2'd1,
    PS_ODD_OK   = 2'd2,
    PS_MISMATCH = 2'd3
  } parity_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    parity_status_t    parity_status;
    logic              stop_valid;
  } rx_result_t;

endpackage

// File: rtl/core/uart_oversampled_receiver.sv
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall   line_level (one sample per tick)
// output   out        out_valid / out_stall rx_byte, parity_status, stop_valid
// config   in         cfg_write             cfg_index, cfg_data
//
// One sample is accepted per clock while in_stall is low; it is held in the
// input register until it fires, and then updates the receiver state.
// A result is loaded into the output register when its stop-bit sample fires.
// Reset returns the receiver to hunting with rx_enable and parity_mode at zero.
// A held output stalls the input only when the waiting sample ends a frame.
module uart_oversampled_receiver import uor_pkg::*; #(
  parameter int OVERSAMPLE = OVERSAMPLE_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  line_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     rx_byte,
  output logic [1:0]            parity_status,
  output logic                  stop_valid
);

  logic         rx_enable;
  parity_mode_t parity_mode;
  logic         s_valid;
  logic         s_level;
  logic         fire;
  logic         res_valid;
  logic         out_free;
  rx_result_t   res;
  rx_result_t   out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable   <= 1'b0;
      parity_mode <= PM_NONE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RX_ENABLE:   rx_enable   <= cfg_data[0];
        REG_PARITY_MODE: parity_mode <= parity_mode_t'(cfg_data);
      endcase
    end
  end

  assign fire = s_valid && (!res_valid || out_free);

  uor_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .line_level (line_level),
    .fire       (fire),
    .s_valid    (s_valid),
    .s_level    (s_level)
  );

  uor_frame #(
    .OVERSAMPLE (OVERSAMPLE),
    .DATA_BITS  (DATA_BITS)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .level       (s_level),
    .rx_enable   (rx_enable),
    .parity_mode (parity_mode),
    .res_valid   (res_valid),
    .res         (res)
  );

  uor_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign rx_byte       = out_res.rx_byte;
  assign parity_status = out_res.parity_status;
  assign stop_valid    = out_res.stop_valid;

endmodule

// File: rtl/core/uor_in_stage.sv
module uor_in_stage import uor_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic line_level,
  input  logic fire,
  output logic s_valid,
  output logic s_level
);

  logic accept;

  assign in_stall = s_valid && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_level <= line_level;
    end
  end

endmodule

// File: rtl/core/uor_frame.sv
module uor_frame import uor_pkg::*; #(
  parameter int OVERSAMPLE = OVERSAMPLE_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic         level,
  input  logic         rx_enable,
  input  parity_mode_t parity_mode,
  output logic         res_valid,
  output rx_result_t   res
);

  localparam int PHASE_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam logic [PHASE_W-1:0]   PHASE_LAST = PHASE_W'(OVERSAMPLE - 1);
  localparam logic [BIT_IDX_W-1:0] IDX_LAST_DATA = BIT_IDX_W'(DATA_BITS);
  localparam logic [BIT_IDX_W-1:0] IDX_PARITY    = BIT_IDX_W'(DATA_BITS + 1);

  logic                 frame_active, frame_active_next;
  logic [HIST_W-1:0]    edge_history, edge_history_next;
  logic [PHASE_W-1:0]   tick_phase, tick_phase_next;
  logic [BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic [DATA_BITS-1:0] shift_data, shift_data_next;
  logic                 ones_odd, ones_odd_next;
  parity_status_t       parity_verdict, parity_verdict_next;
  logic [HIST_W-1:0]    hist_shift;
  logic                 is_stop;

  always_comb begin
    frame_active_next   = frame_active;
    edge_history_next   = edge_history;
    tick_phase_next     = tick_phase;
    bit_index_next      = bit_index;
    shift_data_next     = shift_data;
    ones_odd_next       = ones_odd;
    parity_verdict_next = parity_verdict;
    is_stop             = 1'b0;
    hist_shift          = {edge_history[HIST_W-2:0], level};

    if (rx_enable) begin
      if (!frame_active) begin
        if (hist_shift == START_PATTERN) begin
          frame_active_next   = 1'b1;
          edge_history_next   = '0;
          tick_phase_next     = '0;
          bit_index_next      = '0;
          shift_data_next     = '0;
          ones_odd_next       = 1'b0;
          parity_verdict_next = PS_NONE;
        end else begin
          edge_history_next = hist_shift;
        end
      end else begin
        tick_phase_next = (tick_phase == PHASE_LAST) ? '0 : tick_phase + 1'b1;
        if (tick_phase == PHASE_LAST) begin
          bit_index_next = bit_index + 1'b1;
          if (bit_index_next != '0 && bit_index_next <= IDX_LAST_DATA) begin
            shift_data_next = {level, shift_data[DATA_BITS-1:1]};
            ones_odd_next   = ones_odd ^ level;
          end else if (bit_index_next == IDX_PARITY) begin
            unique case (parity_mode)
              PM_NONE: is_stop = 1'b1;
              PM_EVEN: parity_verdict_next = (ones_odd ^ level) ? PS_MISMATCH : PS_EVEN_OK;
              PM_ODD:  parity_verdict_next = (ones_odd ^ level) ? PS_ODD_OK : PS_MISMATCH;
              PM_SLOT: parity_verdict_next = parity_verdict;
            endcase
          end else begin
            is_stop = 1'b1;
          end
          if (is_stop) begin
            frame_active_next = 1'b0;
          end
        end
      end
    end
  end

  assign res_valid         = is_stop;
  assign res.rx_byte       = BYTE_W'(shift_data);
  assign res.parity_status = parity_verdict;
  assign res.stop_valid    = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active   <= 1'b0;
      edge_history   <= '0;
      tick_phase     <= '0;
      bit_index      <= '0;
      shift_data     <= '0;
      ones_odd       <= 1'b0;
      parity_verdict <= PS_NONE;
    end else if (fire) begin
      frame_active   <= frame_active_next;
      edge_history   <= edge_history_next;
      tick_phase     <= tick_phase_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      ones_odd       <= ones_odd_next;
      parity_verdict <= parity_verdict_next;
    end
  end

  a_hist_clear_in_frame: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> edge_history == '0)
    else $error("edge history not cleared during a frame");

  a_result_in_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> frame_active && rx_enable && tick_phase == PHASE_LAST)
    else $error("result outside a sampled frame bit");

  a_hunt_after_stop: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid |=> !frame_active)
    else $error("frame still active after stop bit");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BIT_IDX_W'(DATA_BITS + 2))
    else $error("bit index beyond stop bit");

endmodule

// File: rtl/core/uor_out_reg.sv
module uor_out_reg import uor_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rx_result_t res,
  output logic       out_free,
  output logic       out_valid,
  input  logic       out_stall,
  output rx_result_t out_res
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule
